// ===== hdl/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erf assertion failed");
`define ERF_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("erf latency assertion failed");
`else
`define ERF_ASSERT_IMPL(lbl, ante, cons)
`define ERF_ASSERT_DELAY(lbl, ante, dly, cons)
`endif
`endif

// ===== hdl/erf_pkg.sv =====
`default_nettype none
package erf_pkg;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [28:0] P_Q30 = 29'd351748265;
  localparam logic signed [33:0] A1_Q30 = 34'sd273621191;
  localparam logic signed [33:0] A2_Q30 = -34'sd305476044;
  localparam logic signed [33:0] A3_Q30 = 34'sd1526231383;
  localparam logic signed [33:0] A4_Q30 = -34'sd1560310108;
  localparam logic signed [33:0] A5_Q30 = 34'sd1139675401;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int EXP_TERMS = 12;
  localparam int RECIP_STEPS = 31;

  typedef struct packed {
    logic vld;
    logic neg;
  } ctl_t;

  // coefficient added after each horner multiply, none after the last
  function automatic logic signed [33:0] horner_coef(input logic [2:0] step);
    logic signed [33:0] c;
    case (step)
      3'd0: c = A4_Q30;
      3'd1: c = A3_Q30;
      3'd2: c = A2_Q30;
      3'd3: c = A1_Q30;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/erf_rational_exp_approx.sv =====
// erf(x) for a signed Q4.12 argument, result signed Q1.15 (+1.0 given as 32767).
// Fully pipelined: one beat may start every cycle and busy never rises. The
// result shows on out_erf_out with out_valid for one cycle; the receiver
// cannot stall, so take it then. The latency is set by the 31-stage reciprocal
// divider plus the ten horner stages, matched by the 42-stage exp(-x^2)
// pipeline running alongside.
`default_nettype none
`include "assert_macros.svh"
module erf_rational_exp_approx (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x_in,
  output logic               out_valid,
  output logic signed [15:0] out_erf_out
);

  // stage index of the last control tap, aligned with the clamped remainder
  localparam int CtlLast = 44;

  // no back-pressure anywhere, a beat can enter every cycle
  assign busy = 1'b0;

  // control travels alongside the data, one tap per stage
  erf_pkg::ctl_t ctl_r [0:CtlLast];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CtlLast; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= '{vld: start, neg: in_x_in[15]};
      for (int k = 1; k <= CtlLast; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // stage 0: magnitude, 8.0 included for the most negative code
  logic [16:0] a_nxt, a_r;

  always_comb begin
    a_nxt = in_x_in[15] ? 17'(17'h10000 - {1'b0, in_x_in}) : {1'b0, in_x_in};
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  // stage 1: d = round((2^42 + a*p) / 2^12) in Q30
  logic [46:0] dsum;
  logic [31:0] d_r;

  always_comb begin
    dsum = (47'd1 << 42) + 47'(a_r) * 47'(erf_pkg::P_Q30) + 47'd2048;
  end

  always_ff @(posedge clk) begin
    d_r <= dsum[43:12];
  end

  // stages 2..32: t = 1/(1 + p*a) in Q30
  logic [30:0] t_w;

  erf_recip u_recip (
    .clk   (clk),
    .d_in  (d_r),
    .t_out (t_w)
  );

  // exp(-a^2) in Q30, ready at stage 42
  logic [30:0] exp_w;

  erf_exp u_exp (
    .clk     (clk),
    .a_in    (a_r),
    .exp_out (exp_w)
  );

  // stages 33..42: horner, multiply stage then round-and-add stage
  logic [30:0]        tl_r [1:8];
  logic [63:0]        hp_r [0:4];
  logic               hn_r [0:4];
  logic signed [33:0] hs_r [1:5];

  always_ff @(posedge clk) begin
    tl_r[1] <= t_w;
    for (int k = 2; k <= 8; k++) begin
      tl_r[k] <= tl_r[k-1];
    end
  end

  genvar j;
  generate
    for (j = 0; j < 5; j++) begin : g_horner
      logic signed [33:0] sin, smag, rnd_s;
      logic [30:0]        tin;
      logic [64:0]        rsum;

      if (j == 0) begin : g_first
        assign sin = erf_pkg::A5_Q30;
        assign tin = t_w;
      end else begin : g_next
        assign sin = hs_r[j];
        assign tin = tl_r[2*j];
      end

      // symmetric rounding: round the magnitude, then restore the sign
      always_comb begin
        smag  = sin[33] ? -sin : sin;
        rsum  = 65'(hp_r[j]) + 65'(30'h2000_0000);
        rnd_s = $signed(rsum[63:30]);
      end

      always_ff @(posedge clk) begin
        hp_r[j]   <= 64'(smag[32:0]) * 64'(tin);
        hn_r[j]   <= sin[33];
        hs_r[j+1] <= (hn_r[j] ? -rnd_s : rnd_s) + erf_pkg::horner_coef(3'(j));
      end
    end
  endgenerate

  // stage 43: P * exp
  logic signed [33:0] poly, pmag;
  logic [63:0]        pm_r;
  logic               pneg_r;

  always_comb begin
    poly = hs_r[5];
    pmag = poly[33] ? -poly : poly;
  end

  always_ff @(posedge clk) begin
    pm_r   <= 64'(pmag[32:0]) * 64'(exp_w);
    pneg_r <= poly[33];
  end

  // stage 44: q = 1 - P*exp, clamped to [0, 1]
  logic [64:0]        psum;
  logic signed [35:0] pe, qv;
  logic [30:0]        q_nxt, q_r;

  always_comb begin
    psum = 65'(pm_r) + 65'(30'h2000_0000);
    pe = $signed({2'b00, psum[63:30]});
    qv = $signed(36'(erf_pkg::Q30_ONE)) - (pneg_r ? -pe : pe);
    if (qv < 0) begin
      q_nxt = '0;
    end else if (qv > $signed(36'(erf_pkg::Q30_ONE))) begin
      q_nxt = erf_pkg::Q30_ONE;
    end else begin
      q_nxt = qv[30:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // stage 45: round to Q1.15, saturate, put the sign back
  logic [31:0]        msum;
  logic [15:0]        m;
  logic signed [15:0] erf_nxt, erf_r;
  logic               out_valid_r;

  always_comb begin
    msum = 32'(q_r) + 32'h4000;
    m = (msum[31:15] > 17'd32767) ? 16'd32767 : msum[30:15];
    erf_nxt = ctl_r[CtlLast].neg ? -$signed(m) : $signed(m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[CtlLast].vld;
    end
    erf_r <= erf_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_erf_out = erf_r;

  // the saturation keeps the most negative code off the output
  `ERF_ASSERT_IMPL(a_no_min_code, out_valid, out_erf_out != 16'sh8000)
  // every start beat comes out after the fixed pipeline latency
  `ERF_ASSERT_DELAY(a_latency, start, 46, out_valid)
  // reciprocal stays in (0, 1]
  `ERF_ASSERT_IMPL(a_t_range, ctl_r[32].vld, (t_w != '0) && (t_w <= erf_pkg::Q30_ONE))
  // clamp holds the remainder inside [0, 1]
  `ERF_ASSERT_IMPL(a_q_range, ctl_r[CtlLast].vld, q_r <= erf_pkg::Q30_ONE)

endmodule
`default_nettype wire

// ===== hdl/erf_recip.sv =====
`default_nettype none
module erf_recip (
  input  logic        clk,
  input  logic [31:0] d_in,
  output logic [30:0] t_out
);

  // restoring division of 2^60 + d/2 by d, one quotient bit per stage
  logic [31:0] rem_r [0:erf_pkg::RECIP_STEPS-1];
  logic [31:0] dv_r  [0:erf_pkg::RECIP_STEPS-1];
  logic [30:0] nl_r  [0:erf_pkg::RECIP_STEPS-1];
  logic [30:0] q_r   [0:erf_pkg::RECIP_STEPS-1];

  genvar j;
  generate
    for (j = 0; j < erf_pkg::RECIP_STEPS; j++) begin : g_step
      localparam int Bit = erf_pkg::RECIP_STEPS - 1 - j;
      logic [31:0] rin, din, rem_nxt;
      logic [30:0] nlin, qin, q_nxt;
      logic [32:0] trial;
      logic        ge;

      if (j == 0) begin : g_first
        // high part of the numerator is 2^29, always below d
        assign rin  = 32'h2000_0000;
        assign din  = d_in;
        assign nlin = d_in[31:1];
        assign qin  = '0;
      end else begin : g_next
        assign rin  = rem_r[j-1];
        assign din  = dv_r[j-1];
        assign nlin = nl_r[j-1];
        assign qin  = q_r[j-1];
      end

      always_comb begin
        trial = {rin, nlin[Bit]};
        ge = trial >= {1'b0, din};
        rem_nxt = ge ? 32'(trial - {1'b0, din}) : trial[31:0];
        q_nxt = qin;
        q_nxt[Bit] = ge;
      end

      always_ff @(posedge clk) begin
        rem_r[j] <= rem_nxt;
        dv_r[j]  <= din;
        nl_r[j]  <= nlin;
        q_r[j]   <= q_nxt;
      end
    end
  endgenerate

  assign t_out = q_r[erf_pkg::RECIP_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/erf_exp.sv =====
`default_nettype none
module erf_exp (
  input  logic        clk,
  input  logic [16:0] a_in,
  output logic [30:0] exp_out
);

  localparam int Steps = erf_pkg::EXP_TERMS;

  logic [30:0] y_r;
  logic [61:0] yl_r;
  logic [37:0] z_r;
  logic [59:0] fl_r;
  logic [7:0]  n1_r, n2_r;
  logic [29:0] u_r;
  logic [62:0] zs;
  logic [60:0] us;

  always_comb begin
    zs = 63'(yl_r) + 63'(24'h80_0000);
    us = 61'(fl_r) + 61'(30'h2000_0000);
  end

  // y = a^2, z = y*log2(e), split into n and f, u = f*ln2
  always_ff @(posedge clk) begin
    y_r  <= 31'(34'(a_in) * 34'(a_in));
    yl_r <= 62'(y_r) * 62'(erf_pkg::LOG2E_Q30);
    z_r  <= zs[61:24];
    fl_r <= 60'(z_r[29:0]) * 60'(erf_pkg::LN2_Q30);
    n1_r <= z_r[37:30];
    u_r  <= us[59:30];
    n2_r <= n1_r;
  end

  // nested taylor terms, k from 12 down to 1, three stages per term
  logic [60:0] w_r  [0:Steps-1];
  logic [63:0] mp_r [0:Steps-1];
  logic [31:0] v_r  [0:Steps-1];
  logic [30:0] r_r  [0:Steps-1];
  logic [29:0] u1_r [0:Steps-1];
  logic [29:0] u2_r [0:Steps-1];
  logic [29:0] u3_r [0:Steps-1];
  logic [7:0]  n1s_r [0:Steps-1];
  logic [7:0]  n2s_r [0:Steps-1];
  logic [7:0]  n3s_r [0:Steps-1];

  genvar i;
  generate
    for (i = 0; i < Steps; i++) begin : g_term
      localparam int Div = 2 * (Steps - i);
      localparam logic [31:0] DivW = 32'(Div);
      localparam logic [31:0] Recip = 32'((64'd1 << 32) / Div);
      localparam logic [31:0] KW = 32'(Steps - i);
      logic [29:0] uin;
      logic [30:0] rin;
      logic [7:0]  nin;
      logic [31:0] vv, q0, rem, qq;

      if (i == 0) begin : g_first
        assign uin = u_r;
        assign rin = erf_pkg::Q30_ONE;
        assign nin = n2_r;
      end else begin : g_next
        assign uin = u3_r[i-1];
        assign rin = r_r[i-1];
        assign nin = n3s_r[i-1];
      end

      // floor((u*r + k*2^29) / (k*2^30)) = floor((u*r/2^29 + k) / 2k)
      always_comb begin
        vv  = w_r[i][60:29] + KW;
        q0  = mp_r[i][63:32];
        rem = v_r[i] - 32'(q0 * DivW);
        qq  = (rem >= DivW) ? q0 + 32'd1 : q0;
      end

      always_ff @(posedge clk) begin
        w_r[i]   <= 61'(uin) * 61'(rin);
        u1_r[i]  <= uin;
        n1s_r[i] <= nin;
        mp_r[i]  <= 64'(vv) * 64'(Recip);
        v_r[i]   <= vv;
        u2_r[i]  <= u1_r[i];
        n2s_r[i] <= n1s_r[i];
        r_r[i]   <= 31'(32'(erf_pkg::Q30_ONE) - qq);
        u3_r[i]  <= u2_r[i];
        n3s_r[i] <= n2s_r[i];
      end
    end
  endgenerate

  // scale by 2^-n with rounding, flush to zero past 31
  logic [7:0]  nfin;
  logic [31:0] half;
  logic [30:0] exp_nxt, exp_r;

  always_comb begin
    nfin = n3s_r[Steps-1];
    half = (nfin == 8'd0) ? 32'd0 : (32'd1 << (nfin[4:0] - 5'd1));
    if (nfin > 8'd31) begin
      exp_nxt = '0;
    end else begin
      exp_nxt = 31'((32'(r_r[Steps-1]) + half) >> nfin[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
  end

  assign exp_out = exp_r;

endmodule
`default_nettype wire
